// ===== rtl/slmc_pkg.sv =====
`default_nettype none
package slmc_pkg;

  // Mask memory geometry
  localparam int MASK_LUMA_ENTRIES = 65536;
  localparam int CHROMA_ENTRIES    = MASK_LUMA_ENTRIES / 4;
  localparam int LUMA_AW           = $clog2(MASK_LUMA_ENTRIES);
  localparam int CHROMA_AW         = $clog2(CHROMA_ENTRIES);
  localparam int LUMA_DEPTH        = 2 * MASK_LUMA_ENTRIES;
  localparam int CHROMA_DEPTH      = 2 * CHROMA_ENTRIES;

  // Row and address arithmetic widths
  localparam int ROW_BITS = 12;
  localparam int BW       = 16;
  localparam int MROW_W   = ROW_BITS + 2;
  localparam int LW_W     = 13;
  localparam int PROD_W   = MROW_W + LW_W;
  localparam int IDX_W    = PROD_W + 1;

  // Input word layout, lowest bit first
  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 16;

  // Opcodes
  localparam logic [1:0] OP_WR_MIX  = 2'd0;
  localparam logic [1:0] OP_WR_OVL  = 2'd1;
  localparam logic [1:0] OP_COMPOSE = 2'd2;

  // Planes
  localparam logic [1:0] PL_LUMA = 2'd0;
  localparam logic [1:0] PL_V    = 2'd1;
  localparam logic [1:0] PL_U    = 2'd2;

  // Result source kinds
  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_COPY  = 2'd1;
  localparam logic [1:0] KIND_BLEND = 2'd2;
  localparam logic [1:0] KIND_OVL   = 2'd3;

  // Register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LETTERBOX_TOP    = 3'd0;
  localparam cfg_idx_t CFG_FREE_TOP_ROWS    = 3'd1;
  localparam cfg_idx_t CFG_MIX_ROWS         = 3'd2;
  localparam cfg_idx_t CFG_FREE_BOTTOM_ROWS = 3'd3;
  localparam cfg_idx_t CFG_MASK_TOP         = 3'd4;
  localparam cfg_idx_t CFG_MASK_HEIGHT      = 3'd5;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT     = 3'd6;
  localparam cfg_idx_t CFG_LINE_WIDTH       = 3'd7;

  localparam logic [12:0] LINE_WIDTH_RESET = 13'd1920;

  // Row bounds of one plane kind, precomputed from the registers
  typedef struct packed {
    logic [BW-1:0]        lb;
    logic [BW-1:0]        ft_end;
    logic [BW-1:0]        b2;
    logic [BW-1:0]        mix_end;
    logic [BW-1:0]        b3;
    logic [BW-1:0]        fb_end;
    logic [BW-1:0]        b4;
    logic [BW-1:0]        ls;
    logic signed [BW-1:0] ov_start;
    logic signed [BW-1:0] ov_lo;
    logic signed [BW-1:0] ov_end;
    logic signed [BW-1:0] bot_lo;
  } bounds_t;

  function automatic logic [BW-1:0] half_u(input logic ch, input logic [BW-1:0] x);
    return ch ? (x >> 1) : x;
  endfunction

  // Halve toward zero, as signed integer division does
  function automatic logic signed [BW-1:0] half_s(input logic ch,
                                                  input logic signed [BW-1:0] x);
    logic signed [BW-1:0] t;
    t = x + $signed({{(BW-1){1'b0}}, x[BW-1]});
    return ch ? (t >>> 1) : x;
  endfunction

  function automatic bounds_t calc_bounds(input logic ch,
                                          input logic [11:0] lt, input logic [11:0] ft,
                                          input logic [11:0] mx, input logic [11:0] fb,
                                          input logic signed [12:0] mt,
                                          input logic [11:0] ih, input logic [11:0] mh);
    logic [BW-1:0]        b2, b3, b4;
    logic signed [BW-1:0] st, mts, lo;
    bounds_t              b;
    b2  = BW'(lt) + BW'(ft);
    b3  = b2 + BW'(mx);
    b4  = b3 + BW'(fb);
    mts = {{(BW-13){mt[12]}}, mt};
    st  = $signed(BW'(lt)) + mts;
    b.lb       = half_u(ch, BW'(lt));
    b.ft_end   = b.lb + half_u(ch, BW'(ft));
    b.b2       = half_u(ch, b2);
    b.mix_end  = b.b2 + half_u(ch, BW'(mx));
    b.b3       = half_u(ch, b3);
    b.fb_end   = b.b3 + half_u(ch, BW'(fb));
    b.b4       = half_u(ch, b4);
    b.ls       = (mts < 0) ? half_u(ch, BW'(-mts)) : '0;
    b.ov_start = half_s(ch, st);
    b.ov_lo    = (b.ov_start < 0) ? '0 : b.ov_start;
    b.ov_end   = half_s(ch, st + $signed(BW'(mh)));
    lo         = $signed(BW'(lt) + BW'(ih));
    if (st > lo) begin
      lo = st;
    end
    b.bot_lo   = half_s(ch, lo);
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/slmc_ram.sv =====
`default_nettype none
module slmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stereo_letterbox_mask_compositor_unit.sv =====
`default_nettype none
// Stereo letterbox and mask compositor: one output pixel of one eye's planar
// 4:2:0 frame per compose request.
// Channels:
//   s_* input stream; each word is a mask write (mix or overlay entry) or a
//       compose request carrying row, column and the source sample.
//   m_* result stream; one word per compose request, none for writes or for
//       words with an unused opcode or plane.
//   cfg_* register writes (zone sizes, mask placement, line width); write
//       them only while the stream is idle. s_tready drops for the cycle
//       after a register write while the row bounds are recomputed.
// Throughput: one word per clock when not stalled. Register stages: zone
// decode, mask address multiply, product hold, address add and memory read,
// blend multiply-add, and divide by 255 into the output register.
// Backpressure: the whole pipeline holds while a result sits in the output
// register and m_tready is low; s_tready drops in the same cycle, so nothing
// is lost or repeated, and a new word is taken as the waiting result leaves.
// Reset clears the valid bits and the registers (line_width to 1920). Mask
// memories are not cleared; load entries before composing with them.
module stereo_letterbox_mask_compositor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // op[1:0] eye[2] plane[4:3] row[16:5] col[28:17] sample[36:29]
  // weight[44:37] color[60:45], zero above
  input  wire logic [slmc_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // pixel[7:0] source_kind[9:8], zero above
  output logic      [slmc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire slmc_pkg::cfg_idx_t                cfg_index,
  input  wire logic [12:0]                       cfg_data
);
  import slmc_pkg::*;

  // Registers
  logic [11:0]        letterbox_top, free_top_rows, mix_rows, free_bottom_rows;
  logic signed [12:0] mask_top;
  logic [11:0]        mask_height, image_height;
  logic [12:0]        line_width;
  logic               cfg_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      letterbox_top    <= '0;
      free_top_rows    <= '0;
      mix_rows         <= '0;
      free_bottom_rows <= '0;
      mask_top         <= '0;
      mask_height      <= '0;
      image_height     <= '0;
      line_width       <= LINE_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LETTERBOX_TOP:    letterbox_top    <= cfg_data[11:0];
        CFG_FREE_TOP_ROWS:    free_top_rows    <= cfg_data[11:0];
        CFG_MIX_ROWS:         mix_rows         <= cfg_data[11:0];
        CFG_FREE_BOTTOM_ROWS: free_bottom_rows <= cfg_data[11:0];
        CFG_MASK_TOP:         mask_top         <= $signed(cfg_data);
        CFG_MASK_HEIGHT:      mask_height      <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT:     image_height     <= cfg_data[11:0];
        CFG_LINE_WIDTH:       line_width       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block input for the cycle after a register write so the bounds catch up
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_busy <= 1'b0;
    end else begin
      cfg_busy <= cfg_valid && cfg_ready;
    end
  end

  // Precompute row bounds for luma and chroma; the user changes registers
  // only while idle (unenforced), and input holds while these registers lag.
  bounds_t            bnd_l, bnd_c;
  logic               mneg, mbot;
  logic signed [BW-1:0] mt_s;

  always_comb begin
    mt_s = {{(BW-13){mask_top[12]}}, mask_top};
  end

  always_ff @(posedge clk) begin
    bnd_l <= calc_bounds(1'b0, letterbox_top, free_top_rows, mix_rows,
                         free_bottom_rows, mask_top, image_height, mask_height);
    bnd_c <= calc_bounds(1'b1, letterbox_top, free_top_rows, mix_rows,
                         free_bottom_rows, mask_top, image_height, mask_height);
    mneg  <= mask_top[12];
    mbot  <= (mt_s + $signed(BW'(mask_height))) > $signed(BW'(image_height));
  end

  // Global advance: hold everything while a result waits
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !cfg_busy;

  // Unpack the input word
  logic [1:0]          in_op, in_plane;
  logic                in_eye;
  logic [ROW_BITS-1:0] in_row;
  logic [11:0]         in_col;
  logic [7:0]          in_sample, in_weight;
  logic [15:0]         in_color;
  assign in_op     = s_tdata[1:0];
  assign in_eye    = s_tdata[2];
  assign in_plane  = s_tdata[4:3];
  assign in_row    = s_tdata[16:5];
  assign in_col    = s_tdata[28:17];
  assign in_sample = s_tdata[36:29];
  assign in_weight = s_tdata[44:37];
  assign in_color  = s_tdata[60:45];

  // Stage 1: zone decode and mask row
  bounds_t              bd;
  logic [BW-1:0]        r_u;
  logic signed [BW-1:0] r_s;
  logic [1:0]           zone_kind;
  logic                 ovl_hit;
  logic [BW-1:0]        mix_mrow, ovl_mrow, sel_mrow;

  always_comb begin
    bd        = (in_plane != PL_LUMA) ? bnd_c : bnd_l;
    r_u       = BW'(in_row);
    r_s       = $signed(r_u);
    if (r_u >= bd.b4) begin
      zone_kind = KIND_FILL;
    end else if (r_u >= bd.b3 && r_u < bd.fb_end) begin
      zone_kind = KIND_COPY;
    end else if (r_u >= bd.b2 && r_u < bd.mix_end) begin
      zone_kind = KIND_BLEND;
    end else if (r_u >= bd.lb && r_u < bd.ft_end) begin
      zone_kind = KIND_COPY;
    end else begin
      zone_kind = KIND_FILL;
    end
    if (mneg) begin
      ovl_hit = (r_s >= bd.ov_lo) && (r_s < bd.ov_end) && (r_u < bd.lb);
    end else if (mbot) begin
      ovl_hit = (r_s >= bd.bot_lo) && (r_s < bd.ov_end);
    end else begin
      ovl_hit = 1'b0;
    end
    mix_mrow = r_u - bd.b2 + bd.ls;
    ovl_mrow = BW'(r_s - bd.ov_start);
    if (in_op != OP_COMPOSE) begin
      sel_mrow = r_u;
    end else if (ovl_hit) begin
      sel_mrow = ovl_mrow;
    end else begin
      sel_mrow = mix_mrow;
    end
  end

  logic              p1_v, p2_v, p3_v, p4_v, p5_v;
  logic [1:0]        p1_op, p2_op, p3_op;
  logic [1:0]        p1_plane, p2_plane, p3_plane, p4_plane, p5_plane;
  logic              p1_eye, p2_eye, p3_eye;
  logic [11:0]       p1_col, p2_col, p3_col;
  logic [7:0]        p1_sample, p2_sample, p3_sample, p4_sample, p5_sample;
  logic [7:0]        p1_weight, p2_weight, p3_weight;
  logic [15:0]       p1_color, p2_color, p3_color;
  logic [1:0]        p1_kind, p2_kind, p3_kind, p4_kind, p5_kind;
  logic [MROW_W-1:0] p1_mrow;
  logic [PROD_W-1:0] p2_prod;
  logic              p4_inr;
  logic [16:0]       p5_sum;
  logic [7:0]        p5_ovl;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
    end else if (adv) begin
      // Drop words with an unused opcode or plane right here
      p1_v <= s_tvalid && !cfg_busy && (in_op == OP_WR_MIX || in_op == OP_WR_OVL ||
              in_op == OP_COMPOSE) && (in_plane == PL_LUMA ||
              in_plane == PL_V || in_plane == PL_U);
      p2_v <= p1_v;
      p3_v <= p2_v;
      // Only compose requests go on past the memory stage
      p4_v <= p3_v && (p3_op == OP_COMPOSE);
      p5_v <= p4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_op     <= in_op;
      p1_plane  <= in_plane;
      p1_eye    <= in_eye;
      p1_col    <= in_col;
      p1_sample <= in_sample;
      p1_weight <= in_weight;
      p1_color  <= in_color;
      p1_kind   <= ovl_hit ? KIND_OVL : zone_kind;
      p1_mrow   <= sel_mrow[MROW_W-1:0];
    end
  end

  // Stage 2: mask row times line stride
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_op     <= p1_op;
      p2_plane  <= p1_plane;
      p2_eye    <= p1_eye;
      p2_col    <= p1_col;
      p2_sample <= p1_sample;
      p2_weight <= p1_weight;
      p2_color  <= p1_color;
      p2_kind   <= p1_kind;
      p2_prod   <= PROD_W'(p1_mrow) * PROD_W'(line_width);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_op     <= p2_op;
      p3_plane  <= p2_plane;
      p3_eye    <= p2_eye;
      p3_col    <= p2_col;
      p3_sample <= p2_sample;
      p3_weight <= p2_weight;
      p3_color  <= p2_color;
      p3_kind   <= p2_kind;
    end
  end

  // Stage 3 holds the product; add the column, range check, access memory
  logic [PROD_W-1:0] p3_prod;
  always_ff @(posedge clk) begin
    if (adv) begin
      p3_prod <= p2_prod;
    end
  end

  logic [IDX_W-1:0]  idx;
  logic              chroma3, inr;
  logic [LUMA_AW:0]   luma_addr;
  logic [CHROMA_AW:0] chroma_addr;
  logic              wr_mix, wr_ovl;
  logic              we_wl, we_cl, we_wc, we_cv, we_cu, we_ol, we_ov, we_ou;

  always_comb begin
    chroma3 = (p3_plane != PL_LUMA);
    idx     = (chroma3 ? IDX_W'(p3_prod >> 1) : IDX_W'(p3_prod)) + IDX_W'(p3_col);
    inr     = chroma3 ? (idx < IDX_W'(CHROMA_ENTRIES)) :
                        (idx < IDX_W'(MASK_LUMA_ENTRIES));
    luma_addr   = {p3_eye, idx[LUMA_AW-1:0]};
    chroma_addr = {p3_eye, idx[CHROMA_AW-1:0]};
    wr_mix  = adv && p3_v && inr && (p3_op == OP_WR_MIX);
    wr_ovl  = adv && p3_v && inr && (p3_op == OP_WR_OVL);
    we_wl   = wr_mix && !chroma3;
    we_cl   = wr_mix && !chroma3;
    we_wc   = wr_mix && chroma3;
    we_cv   = wr_mix && (p3_plane == PL_V);
    we_cu   = wr_mix && (p3_plane == PL_U);
    we_ol   = wr_ovl && (p3_plane == PL_LUMA);
    we_ov   = wr_ovl && (p3_plane == PL_V);
    we_ou   = wr_ovl && (p3_plane == PL_U);
  end

  logic [7:0]  q_wl, q_wc, q_ol, q_ov, q_ou;
  logic [15:0] q_cl, q_cv, q_cu;

  slmc_ram #(.WIDTH(8), .DEPTH(LUMA_DEPTH)) u_mix_weight_luma (
    .clk(clk), .we(we_wl), .waddr(luma_addr), .wdata(p3_weight),
    .re(adv), .raddr(luma_addr), .rdata(q_wl));
  slmc_ram #(.WIDTH(16), .DEPTH(LUMA_DEPTH)) u_mix_color_luma (
    .clk(clk), .we(we_cl), .waddr(luma_addr), .wdata(p3_color),
    .re(adv), .raddr(luma_addr), .rdata(q_cl));
  slmc_ram #(.WIDTH(8), .DEPTH(CHROMA_DEPTH)) u_mix_weight_chroma (
    .clk(clk), .we(we_wc), .waddr(chroma_addr), .wdata(p3_weight),
    .re(adv), .raddr(chroma_addr), .rdata(q_wc));
  slmc_ram #(.WIDTH(16), .DEPTH(CHROMA_DEPTH)) u_mix_color_v (
    .clk(clk), .we(we_cv), .waddr(chroma_addr), .wdata(p3_color),
    .re(adv), .raddr(chroma_addr), .rdata(q_cv));
  slmc_ram #(.WIDTH(16), .DEPTH(CHROMA_DEPTH)) u_mix_color_u (
    .clk(clk), .we(we_cu), .waddr(chroma_addr), .wdata(p3_color),
    .re(adv), .raddr(chroma_addr), .rdata(q_cu));
  slmc_ram #(.WIDTH(8), .DEPTH(LUMA_DEPTH)) u_overlay_luma (
    .clk(clk), .we(we_ol), .waddr(luma_addr), .wdata(p3_color[7:0]),
    .re(adv), .raddr(luma_addr), .rdata(q_ol));
  slmc_ram #(.WIDTH(8), .DEPTH(CHROMA_DEPTH)) u_overlay_v (
    .clk(clk), .we(we_ov), .waddr(chroma_addr), .wdata(p3_color[7:0]),
    .re(adv), .raddr(chroma_addr), .rdata(q_ov));
  slmc_ram #(.WIDTH(8), .DEPTH(CHROMA_DEPTH)) u_overlay_u (
    .clk(clk), .we(we_ou), .waddr(chroma_addr), .wdata(p3_color[7:0]),
    .re(adv), .raddr(chroma_addr), .rdata(q_ou));

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_plane  <= p3_plane;
      p4_sample <= p3_sample;
      p4_kind   <= p3_kind;
      p4_inr    <= inr;
    end
  end

  // Stage 4: pick the entries (out of range reads as zero), multiply-add
  logic [7:0]  w4, o4;
  logic [15:0] c4;
  always_comb begin
    case (p4_plane)
      PL_LUMA: begin
        w4 = q_wl;
        c4 = q_cl;
        o4 = q_ol;
      end
      PL_V: begin
        w4 = q_wc;
        c4 = q_cv;
        o4 = q_ov;
      end
      default: begin
        w4 = q_wc;
        c4 = q_cu;
        o4 = q_ou;
      end
    endcase
    if (!p4_inr) begin
      w4 = '0;
      c4 = '0;
      o4 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_plane  <= p4_plane;
      p5_sample <= p4_sample;
      p5_kind   <= p4_kind;
      p5_ovl    <= o4;
      p5_sum    <= 17'(p4_sample) * 17'(w4) + 17'(c4);
    end
  end

  // Stage 5: divide by 255 through the reciprocal 257/65536, then correct once
  logic [25:0] recip;
  logic [9:0]  q5;
  logic [17:0] rem5;
  logic [9:0]  quo;
  logic [7:0]  blend, pix5;
  always_comb begin
    recip = 26'(p5_sum) + (26'(p5_sum) << 8);
    q5    = recip[25:16];
    rem5  = 18'(p5_sum) - ((18'(q5) << 8) - 18'(q5));
    quo   = (rem5 >= 18'd255) ? q5 + 10'd1 : q5;
    blend = (quo > 10'd255) ? 8'd255 : quo[7:0];
    case (p5_kind)
      KIND_FILL:  pix5 = (p5_plane != PL_LUMA) ? 8'd128 : 8'd0;
      KIND_COPY:  pix5 = p5_sample;
      KIND_BLEND: pix5 = blend;
      KIND_OVL:   pix5 = p5_ovl;
      default:    pix5 = 8'd0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= p5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {6'd0, p5_kind, pix5};
    end
  end

`ifndef SYNTHESIS
  // A letterbox fill word is always black luma or neutral chroma
  a_fill_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9:8] == KIND_FILL) |->
      (m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd128))
    else $error("letterbox fill value is neither 0 nor 128");

  // Words with an unused opcode or plane never enter the pipeline
  a_stage1_legal: assert property (@(posedge clk) disable iff (rst)
    p1_v |-> ((p1_op == OP_WR_MIX || p1_op == OP_WR_OVL || p1_op == OP_COMPOSE) &&
              (p1_plane == PL_LUMA || p1_plane == PL_V || p1_plane == PL_U)))
    else $error("illegal word reached stage 1");

  // While stalled, the blend stage holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!adv && !$past(rst)) |=> ($stable(p5_sum) && $stable(p5_kind) && $stable(p5_v)))
    else $error("blend stage changed during a stall");

  // Only compose requests reach stage 4, past the memory read
  a_no_write_result: assert property (@(posedge clk) disable iff (rst)
    (adv && p3_v && p3_op != OP_COMPOSE) |=> !p4_v)
    else $error("mask write produced a result");
`endif

endmodule
`default_nettype wire
